@@ design/reos_pkg.sv @@
package reos_pkg;

  localparam int CODE_W    = 3;
  localparam int PAT_W     = 48;
  localparam int PLEN_W    = 5;
  localparam int OVL_W     = 5;
  localparam int RLEN_W    = 16;
  localparam int CNT_W     = 32;
  localparam int SQ_W      = 40;
  localparam int TOT_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 48;
  localparam int OVSQ_W    = 2 * OVL_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIVE_PATTERN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIVE_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_PATTERN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_LENGTH  = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] base;
    logic              last_base;
    logic              clear_totals;
  } item_t;

  typedef struct packed {
    logic [RLEN_W-1:0] read_length;
    logic [OVL_W-1:0]  five_overlap;
    logic [OVL_W-1:0]  three_overlap;
    logic [CNT_W-1:0]  reads_seen;
    logic [RLEN_W-1:0] longest_read;
    logic [TOT_W-1:0]  total_bases;
    logic [CNT_W-1:0]  five_hits;
    logic [CNT_W-1:0]  five_sum;
    logic [SQ_W-1:0]   five_sum_sq;
    logic [CNT_W-1:0]  three_hits;
    logic [CNT_W-1:0]  three_sum;
    logic [SQ_W-1:0]   three_sum_sq;
  } result_t;

endpackage

@@ design/reos_stream_if.sv @@
interface reos_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ design/read_end_overlap_stats_top.sv @@
// Read end overlap statistics.
// item_i takes one base code per beat; last_base closes the read and
// clear_totals zeroes the per-file totals before that beat is counted.
// result_o gives one beat per finished read: read length, the 5' overlap
// (longest suffix of the 5' pattern equal to the read start), the 3'
// overlap (longest prefix of the 3' pattern equal to the read end), each
// counted only above 3 bases, plus the saturating totals after that read.
// The cfg_* port writes the pattern registers; write only while idle.
// Throughput: one base per cycle, also across read boundaries, bar stalls.
// The overlaps of a read's last beat are registered on the accepting edge;
// totals and the result register follow when stage 1 passes it on, which
// waits only while an earlier result is still held.
// The compare is a fixed parallel array over MAX_PATTERN positions.
// Stall: a held result blocks only a read end behind it; plain bases keep
// flowing; item_i.ready drops while stage 1 holds such a blocked read end.
// Reset clears lengths, totals, patterns and valid flags; the stored read
// start and end windows are not cleared and are only read once written.
module read_end_overlap_stats_top #(
  parameter int MAX_PATTERN = 16,
  parameter int LENGTH_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [reos_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [reos_pkg::CFG_W-1:0]     cfg_data_i,
  reos_stream_if.sink                   item_i,
  reos_stream_if.source                 result_o
);
  import reos_pkg::*;

  localparam int PW   = MAX_PATTERN * CODE_W;
  localparam int PX_W = (PW > PAT_W) ? PW : PAT_W;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [PAT_W-1:0]  five_pat_q, three_pat_q;
  logic [PLEN_W-1:0] five_len_q, three_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      five_pat_q  <= '0;
      five_len_q  <= '0;
      three_pat_q <= '0;
      three_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIVE_PATTERN:  five_pat_q  <= cfg_data_i[PAT_W-1:0];
        REG_FIVE_LENGTH:   five_len_q  <= cfg_data_i[PLEN_W-1:0];
        REG_THREE_PATTERN: three_pat_q <= cfg_data_i[PAT_W-1:0];
        REG_THREE_LENGTH:  three_len_q <= cfg_data_i[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // codes past the 48-bit register read as zero
  logic [PX_W-1:0]   five_px, three_px;
  logic [PLEN_W-1:0] five_l, three_l;

  assign five_px  = PX_W'(five_pat_q);
  assign three_px = PX_W'(three_pat_q);
  assign five_l   = (five_len_q > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN) : five_len_q;
  assign three_l  = (three_len_q > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN) : three_len_q;

  // ---------------------------------------------------------------------
  // Handshake and stage control
  // ---------------------------------------------------------------------
  logic s1_valid_q, s1_go, out_free, in_acc, out_valid_q;
  logic s1_last_q, s1_clr_q;

  assign out_free     = !out_valid_q || result_o.ready;
  assign s1_go        = s1_valid_q && (!s1_last_q || out_free);
  assign item_i.ready = !s1_valid_q || s1_go;
  assign in_acc       = item_i.valid && item_i.ready;

  // ---------------------------------------------------------------------
  // Read tracking: length, start of read, window over the end
  // ---------------------------------------------------------------------
  logic [LENGTH_BITS-1:0] len_q, len_inc;
  logic [CODE_W-1:0]      prefix_q [MAX_PATTERN];
  logic [CODE_W-1:0]      win_q    [MAX_PATTERN];
  logic [CODE_W-1:0]      win_d    [MAX_PATTERN];

  assign len_inc = (&len_q) ? len_q : len_q + LENGTH_BITS'(1);

  always_comb begin
    win_d[0] = item_i.payload.base;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (in_acc) begin
      len_q <= item_i.payload.last_base ? '0 : len_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_q[k] <= win_d[k];
        if (len_q == LENGTH_BITS'(k)) begin
          prefix_q[k] <= item_i.payload.base;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Overlap compare. 5': try each start s in the pattern, the suffix from s
  // must equal the read start; smallest s wins. 3': try each length m, the
  // last m bases must equal the pattern head; largest m wins. The current
  // base never takes part in the 5' test (pattern shorter than read).
  // ---------------------------------------------------------------------
  logic [OVL_W-1:0] five_ov, three_ov;
  logic             five_ok, three_ok;

  assign five_ok  = (LENGTH_BITS'(five_l) < len_inc) && (five_l > PLEN_W'(3));
  assign three_ok = (LENGTH_BITS'(three_l) < len_inc) && (three_l > PLEN_W'(3));

  always_comb begin
    logic diag;
    five_ov = '0;
    for (int s = MAX_PATTERN - 4; s >= 0; s--) begin
      diag = 1'b1;
      for (int j = 0; j < MAX_PATTERN - s; j++) begin
        if ((6'(s + j) < {1'b0, five_l}) &&
            (prefix_q[j] != five_px[(s+j)*CODE_W +: CODE_W])) begin
          diag = 1'b0;
        end
      end
      if (diag && ({1'b0, five_l} >= 6'(s + 4))) begin
        five_ov = five_l - OVL_W'(s);
      end
    end
    if (!five_ok) begin
      five_ov = '0;
    end
  end

  always_comb begin
    logic hit;
    three_ov = '0;
    for (int m = 4; m <= MAX_PATTERN; m++) begin
      hit = 1'b1;
      for (int j = 0; j < m; j++) begin
        if (win_d[m-1-j] != three_px[j*CODE_W +: CODE_W]) begin
          hit = 1'b0;
        end
      end
      if (hit && (PLEN_W'(m) <= three_l)) begin
        three_ov = OVL_W'(m);
      end
    end
    if (!three_ok) begin
      three_ov = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1 register: every accepted beat passes, so clears stay in order
  // ---------------------------------------------------------------------
  logic [LENGTH_BITS-1:0] s1_rlen_q;
  logic [OVL_W-1:0]       s1_five_q, s1_three_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_last_q  <= item_i.payload.last_base;
      s1_clr_q   <= item_i.payload.clear_totals;
      s1_rlen_q  <= len_inc;
      s1_five_q  <= five_ov;
      s1_three_q <= three_ov;
    end
  end

  // ---------------------------------------------------------------------
  // Totals update
  // ---------------------------------------------------------------------
  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  function automatic logic [SQ_W-1:0] sat_sq(input logic [SQ_W-1:0] a,
                                             input logic [SQ_W-1:0] b);
    logic [SQ_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SQ_W] ? '1 : s[SQ_W-1:0];
  endfunction

  function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W-1:0] a,
                                               input logic [TOT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOT_W] ? '1 : s[TOT_W-1:0];
  endfunction

  logic [CNT_W-1:0]       reads_q, reads_b, reads_n;
  logic [LENGTH_BITS-1:0] max_q, max_b, max_n;
  logic [TOT_W-1:0]       tot_q, tot_b, tot_n;
  logic [CNT_W-1:0]       fh_q, fh_b, fh_n, fs_q, fs_b, fs_n;
  logic [SQ_W-1:0]        fq_q, fq_b, fq_n;
  logic [CNT_W-1:0]       th_q, th_b, th_n, ts_q, ts_b, ts_n;
  logic [SQ_W-1:0]        tq_q, tq_b, tq_n;
  logic [OVSQ_W-1:0]      five_sq, three_sq;

  assign five_sq  = OVSQ_W'(s1_five_q) * OVSQ_W'(s1_five_q);
  assign three_sq = OVSQ_W'(s1_three_q) * OVSQ_W'(s1_three_q);

  always_comb begin
    reads_b = s1_clr_q ? '0 : reads_q;
    max_b   = s1_clr_q ? '0 : max_q;
    tot_b   = s1_clr_q ? '0 : tot_q;
    fh_b    = s1_clr_q ? '0 : fh_q;
    fs_b    = s1_clr_q ? '0 : fs_q;
    fq_b    = s1_clr_q ? '0 : fq_q;
    th_b    = s1_clr_q ? '0 : th_q;
    ts_b    = s1_clr_q ? '0 : ts_q;
    tq_b    = s1_clr_q ? '0 : tq_q;

    reads_n = sat_cnt(reads_b, CNT_W'(1));
    max_n   = (s1_rlen_q > max_b) ? s1_rlen_q : max_b;
    tot_n   = sat_tot(tot_b, TOT_W'(s1_rlen_q));

    fh_n = fh_b;
    fs_n = fs_b;
    fq_n = fq_b;
    if (s1_five_q != '0) begin
      fh_n = sat_cnt(fh_b, CNT_W'(1));
      fs_n = sat_cnt(fs_b, CNT_W'(s1_five_q));
      fq_n = sat_sq(fq_b, SQ_W'(five_sq));
    end

    th_n = th_b;
    ts_n = ts_b;
    tq_n = tq_b;
    if (s1_three_q != '0) begin
      th_n = sat_cnt(th_b, CNT_W'(1));
      ts_n = sat_cnt(ts_b, CNT_W'(s1_three_q));
      tq_n = sat_sq(tq_b, SQ_W'(three_sq));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reads_q <= '0;
      max_q   <= '0;
      tot_q   <= '0;
      fh_q    <= '0;
      fs_q    <= '0;
      fq_q    <= '0;
      th_q    <= '0;
      ts_q    <= '0;
      tq_q    <= '0;
    end else if (s1_go) begin
      if (s1_last_q) begin
        reads_q <= reads_n;
        max_q   <= max_n;
        tot_q   <= tot_n;
        fh_q    <= fh_n;
        fs_q    <= fs_n;
        fq_q    <= fq_n;
        th_q    <= th_n;
        ts_q    <= ts_n;
        tq_q    <= tq_n;
      end else begin
        reads_q <= reads_b;
        max_q   <= max_b;
        tot_q   <= tot_b;
        fh_q    <= fh_b;
        fs_q    <= fs_b;
        fq_q    <= fq_b;
        th_q    <= th_b;
        ts_q    <= ts_b;
        tq_q    <= tq_b;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_go && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      out_q.read_length   <= RLEN_W'(s1_rlen_q);
      out_q.five_overlap  <= s1_five_q;
      out_q.three_overlap <= s1_three_q;
      out_q.reads_seen    <= reads_n;
      out_q.longest_read  <= RLEN_W'(max_n);
      out_q.total_bases   <= tot_n;
      out_q.five_hits     <= fh_n;
      out_q.five_sum      <= fs_n;
      out_q.five_sum_sq   <= fq_n;
      out_q.three_hits    <= th_n;
      out_q.three_sum     <= ts_n;
      out_q.three_sum_sq  <= tq_n;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

endmodule

@@ tb/sv/read_end_overlap_stats_top_test.sv @@
module read_end_overlap_stats_top_test;
  import reos_pkg::*;

  // Nucleotide codes; 5 to 7 are unassigned but still legal on the wire
  localparam logic [CODE_W-1:0] NT_A = 3'd0;
  localparam logic [CODE_W-1:0] NT_C = 3'd1;
  localparam logic [CODE_W-1:0] NT_G = 3'd2;
  localparam logic [CODE_W-1:0] NT_T = 3'd3;
  localparam logic [CODE_W-1:0] NT_N = 3'd4;

  localparam int WINDOW      = 16;    // MAX_PATTERN of the block
  localparam int SETTLE_CYC  = 4;     // settle tail after the last result, with margin
  localparam int STALL_LIMIT = 3000;  // cycles without any beat before giving up
  localparam int PHASE_BASES = 170;   // 3 idling modes x 4 settings x 170 ~ 2000

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  reos_stream_if #(.T(item_t))   item_if ();
  reos_stream_if #(.T(result_t)) res_if ();

  read_end_overlap_stats_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .result_o   (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: pattern registers, read start/end windows, totals
  // ---------------------------------------------------------------------------
  logic [PAT_W-1:0]  cfg_five_pat, cfg_three_pat;
  logic [PLEN_W-1:0] cfg_five_len, cfg_three_len;
  logic [CODE_W-1:0] rd_head [WINDOW];  // first bases of the read
  logic [CODE_W-1:0] rd_tail [WINDOW];  // last bases, entry 0 newest
  logic [RLEN_W-1:0] cur_len;
  logic [CNT_W-1:0]  n_reads, f_hits, f_sum, t_hits, t_sum;
  logic [RLEN_W-1:0] max_len;
  logic [TOT_W-1:0]  base_sum;
  logic [SQ_W-1:0]   f_sq, t_sq;

  result_t pending_reads [$];  // expected result beats, oldest first

  int errors        = 0;
  int reads_checked = 0;
  int bases_taken   = 0;
  int quiet_cycles  = 0;
  int phase_bases   = 0;
  int src_idle_pct  = 0;
  int snk_idle_pct  = 0;
  int recv_hold     = 0;
  int settings_run  = 0;

  // typed-in expectation attached to the beat currently offered
  bit                pin_on;
  logic [RLEN_W-1:0] pin_len;
  logic [OVL_W-1:0]  pin_five, pin_three;

  function automatic logic [63:0] capped_sum(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] lim);
    if (a >= lim || b >= lim - a) return lim;
    return a + b;
  endfunction

  function automatic int unsigned clamp_len(logic [PLEN_W-1:0] l);
    return (l > WINDOW) ? WINDOW : l;
  endfunction

  // longest suffix of the 5' pattern equal to the read start
  function automatic logic [OVL_W-1:0] five_overlap_of(logic [RLEN_W-1:0] rlen);
    int unsigned lim;
    bit hit;
    lim = clamp_len(cfg_five_len);
    if (lim >= rlen) return '0;
    for (int m = lim; m > 3; m--) begin
      hit = 1'b1;
      for (int j = 0; j < m; j++)
        if (rd_head[j] != cfg_five_pat[3*(lim-m+j) +: 3]) hit = 1'b0;
      if (hit) return OVL_W'(m);
    end
    return '0;
  endfunction

  // longest prefix of the 3' pattern equal to the read end
  function automatic logic [OVL_W-1:0] three_overlap_of(logic [RLEN_W-1:0] rlen);
    int unsigned lim;
    bit hit;
    lim = clamp_len(cfg_three_len);
    if (lim >= rlen) return '0;
    for (int m = lim; m > 3; m--) begin
      hit = 1'b1;
      for (int j = 0; j < m; j++)
        if (rd_tail[m-1-j] != cfg_three_pat[3*j +: 3]) hit = 1'b0;
      if (hit) return OVL_W'(m);
    end
    return '0;
  endfunction

  function automatic void zero_totals();
    n_reads = '0; max_len = '0; base_sum = '0;
    f_hits = '0; f_sum = '0; f_sq = '0;
    t_hits = '0; t_sum = '0; t_sq = '0;
  endfunction

  // Takes one base; on a read end, returns the result beat it should give.
  task automatic absorb_base(input item_t it, output bit closed, output result_t r);
    logic [RLEN_W-1:0] rlen;
    logic [OVL_W-1:0]  fo, tov;
    closed = 1'b0;
    r = '0;
    if (it.clear_totals) zero_totals();
    if (cur_len < WINDOW) rd_head[cur_len] = it.base;
    for (int k = WINDOW - 1; k > 0; k--) rd_tail[k] = rd_tail[k-1];
    rd_tail[0] = it.base;
    if (cur_len != '1) cur_len++;
    if (!it.last_base) return;

    rlen = cur_len;
    fo   = five_overlap_of(rlen);
    tov  = three_overlap_of(rlen);
    n_reads  = CNT_W'(capped_sum(64'(n_reads), 64'd1, 64'hFFFF_FFFF));
    if (rlen > max_len) max_len = rlen;
    base_sum = TOT_W'(capped_sum(64'(base_sum), 64'(rlen), 64'hFFFF_FFFF_FFFF));
    if (fo != 0) begin
      f_hits = CNT_W'(capped_sum(64'(f_hits), 64'd1, 64'hFFFF_FFFF));
      f_sum  = CNT_W'(capped_sum(64'(f_sum), 64'(fo), 64'hFFFF_FFFF));
      f_sq   = SQ_W'(capped_sum(64'(f_sq), 64'(fo) * 64'(fo), 64'hFF_FFFF_FFFF));
    end
    if (tov != 0) begin
      t_hits = CNT_W'(capped_sum(64'(t_hits), 64'd1, 64'hFFFF_FFFF));
      t_sum  = CNT_W'(capped_sum(64'(t_sum), 64'(tov), 64'hFFFF_FFFF));
      t_sq   = SQ_W'(capped_sum(64'(t_sq), 64'(tov) * 64'(tov), 64'hFF_FFFF_FFFF));
    end
    r.read_length   = rlen;
    r.five_overlap  = fo;
    r.three_overlap = tov;
    r.reads_seen    = n_reads;
    r.longest_read  = max_len;
    r.total_bases   = base_sum;
    r.five_hits     = f_hits;
    r.five_sum      = f_sum;
    r.five_sum_sq   = f_sq;
    r.three_hits    = t_hits;
    r.three_sum     = t_sum;
    r.three_sum_sq  = t_sq;
    cur_len = '0;
    closed  = 1'b1;
  endtask

  task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : observe
    result_t want, got;
    bit closed, moved;
    moved = 1'b0;
    // result side first: a result never belongs to a base taken on this edge
    if (res_if.valid && res_if.ready) begin
      moved = 1'b1;
      got = res_if.payload;
      if (pending_reads.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, got %h", $time, got);
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        check_field("read_length",   64'(want.read_length),   64'(got.read_length));
        check_field("five_overlap",  64'(want.five_overlap),  64'(got.five_overlap));
        check_field("three_overlap", 64'(want.three_overlap), 64'(got.three_overlap));
        check_field("reads_seen",    64'(want.reads_seen),    64'(got.reads_seen));
        check_field("longest_read",  64'(want.longest_read),  64'(got.longest_read));
        check_field("total_bases",   64'(want.total_bases),   64'(got.total_bases));
        check_field("five_hits",     64'(want.five_hits),     64'(got.five_hits));
        check_field("five_sum",      64'(want.five_sum),      64'(got.five_sum));
        check_field("five_sum_sq",   64'(want.five_sum_sq),   64'(got.five_sum_sq));
        check_field("three_hits",    64'(want.three_hits),    64'(got.three_hits));
        check_field("three_sum",     64'(want.three_sum),     64'(got.three_sum));
        check_field("three_sum_sq",  64'(want.three_sum_sq),  64'(got.three_sum_sq));
      end
    end
    if (item_if.valid && item_if.ready) begin
      moved = 1'b1;
      bases_taken++;
      phase_bases++;
      absorb_base(item_if.payload, closed, want);
      if (closed) begin
        // directed rows carry their length and overlaps typed in
        if (pin_on) begin
          want.read_length   = pin_len;
          want.five_overlap  = pin_five;
          want.three_overlap = pin_three;
        end
        pending_reads.push_back(want);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // Watchdog: nothing moving on either channel for too long
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no beat for %0d cycles, %0d reads outstanding", $time,
             STALL_LIMIT, pending_reads.size());
    $display("** read_end_overlap_stats_top: FAILED **");
    $finish;
  end

  // Receiver: random back-pressure, or a counted hold-off when asked for
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_hold > 0) begin
        res_if.ready <= 1'b0;
        recv_hold--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------
  // Offers one base beat, with random idle cycles in front, and holds it
  // until the block takes it. valid is only touched once per falling edge.
  task automatic offer_base(item_t it, bit pin, logic [RLEN_W-1:0] plen,
                            logic [OVL_W-1:0] pfive, logic [OVL_W-1:0] pthree);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      item_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    pin_on    = pin;
    pin_len   = plen;
    pin_five  = pfive;
    pin_three = pthree;
    do @(posedge clk_i); while (!item_if.ready);
  endtask

  // Stops offering and waits until every read end has given its result;
  // the last plain bases may still be in the pipe, hence the short tail.
  task automatic drain_reads();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
  endtask

  // Writes all four pattern registers (block idle) and mirrors them.
  task automatic load_config(logic [PAT_W-1:0] fpat, logic [PLEN_W-1:0] flen,
                             logic [PAT_W-1:0] tpat, logic [PLEN_W-1:0] tlen);
    set_reg(REG_FIVE_PATTERN,  CFG_W'(fpat));
    set_reg(REG_FIVE_LENGTH,   CFG_W'(flen));
    set_reg(REG_THREE_PATTERN, CFG_W'(tpat));
    set_reg(REG_THREE_LENGTH,  CFG_W'(tlen));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_five_pat  = fpat;
    cfg_five_len  = flen;
    cfg_three_pat = tpat;
    cfg_three_len = tlen;
    settings_run++;
  endtask

  // Patterns lean on A/C/G/T so that partial and nested overlaps turn up;
  // now and then all zeros, all ones or fully random 3-bit codes.
  function automatic logic [PAT_W-1:0] random_pattern();
    logic [PAT_W-1:0] p;
    logic [CODE_W-1:0] c0, c1;
    int style;
    style = $urandom_range(9);
    c0 = CODE_W'($urandom_range(3));
    c1 = CODE_W'($urandom_range(3));
    case (style)
      0: p = '0;
      1: p = '1;
      2: p = PAT_W'({$urandom(), $urandom()});
      3: for (int k = 0; k < WINDOW; k++) p[3*k +: 3] = $urandom_range(1) ? c0 : c1;
      default: for (int k = 0; k < WINDOW; k++) p[3*k +: 3] = CODE_W'($urandom_range(3));
    endcase
    return p;
  endfunction

  // Mostly useful lengths, but also off, too short and beyond the window
  function automatic logic [PLEN_W-1:0] random_length();
    case ($urandom_range(9))
      0:       return '0;
      1:       return PLEN_W'($urandom_range(31, 17));
      2:       return PLEN_W'($urandom_range(4, 1));
      default: return PLEN_W'($urandom_range(16, 5));
    endcase
  endfunction

  // One read: random bases, mostly framed by a piece of the 5' pattern at
  // the start and of the 3' pattern at the end, sometimes with one base hit.
  task automatic play_read();
    logic [CODE_W-1:0] seq [48];
    item_t it;
    int len, m, lim;
    len = ($urandom_range(9) == 0) ? $urandom_range(48, 17) : $urandom_range(20, 1);
    for (int i = 0; i < len; i++)
      seq[i] = ($urandom_range(11) == 0) ? CODE_W'($urandom_range(7))
                                         : CODE_W'($urandom_range(4));
    if ($urandom_range(4) != 0) begin
      lim = clamp_len(cfg_five_len);
      m = $urandom_range(lim);
      for (int j = 0; j < m && j < len; j++) seq[j] = cfg_five_pat[3*(lim-m+j) +: 3];
      lim = clamp_len(cfg_three_len);
      m = $urandom_range(lim);
      for (int j = 0; j < m; j++)
        if (len - m + j >= 0) seq[len-m+j] = cfg_three_pat[3*j +: 3];
      if ($urandom_range(5) == 0) seq[$urandom_range(len - 1)] = CODE_W'($urandom_range(7));
    end
    for (int i = 0; i < len; i++) begin
      it.base         = seq[i];
      it.last_base    = (i == len - 1);
      it.clear_totals = ($urandom_range(39) == 0);
      offer_base(it, 1'b0, '0, '0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    int                setting;   // which register setting the row runs under
    item_t             it;
    bit                pinned;    // length and overlaps typed in below
    logic [RLEN_W-1:0] len;
    logic [OVL_W-1:0]  five_ov;
    logic [OVL_W-1:0]  three_ov;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_row(int setting, logic [CODE_W-1:0] b, bit last,
                                  bit clr, bit pin, logic [RLEN_W-1:0] len,
                                  logic [OVL_W-1:0] fo, logic [OVL_W-1:0] tov);
    dir_row_t row;
    row.setting         = setting;
    row.it.base         = b;
    row.it.last_base    = last;
    row.it.clear_totals = clr;
    row.pinned          = pin;
    row.len             = len;
    row.five_ov         = fo;
    row.three_ov        = tov;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int cur_setting;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    item_if.valid   = 1'b0;
    item_if.payload = '0;
    pin_on          = 1'b0;
    cfg_five_pat    = '0;
    cfg_five_len    = '0;
    cfg_three_pat   = '0;
    cfg_three_len   = '0;
    cur_len         = '0;
    for (int k = 0; k < WINDOW; k++) begin
      rd_head[k] = '0;
      rd_tail[k] = '0;
    end
    zero_totals();

    // Setting 0, registers as after reset: a one-base N read with a clear.
    add_row(0, NT_N, 1, 1, 1, 1, 0, 0);
    // Setting 1: 5' pattern T T A C G T (6), 3' pattern G A T C C (5).
    // ACGT opens the read -> 5' overlap of 4; GATCC closes it -> 3' of 5.
    add_row(1, NT_A, 0, 0, 0, 0, 0, 0);
    add_row(1, NT_C, 0, 0, 0, 0, 0, 0);
    add_row(1, NT_G, 0, 0, 0, 0, 0, 0);
    add_row(1, NT_T, 0, 0, 0, 0, 0, 0);
    add_row(1, NT_G, 0, 0, 0, 0, 0, 0);
    add_row(1, NT_A, 0, 0, 0, 0, 0, 0);
    add_row(1, NT_T, 0, 0, 0, 0, 0, 0);
    add_row(1, NT_C, 0, 0, 0, 0, 0, 0);
    add_row(1, NT_C, 1, 0, 1, 9, 4, 5);
    // Five-base read, both patterns not shorter than it -> no overlaps.
    // Unassigned codes in the read, totals cleared mid-read.
    add_row(1, 3'd7, 0, 0, 0, 0, 0, 0);
    add_row(1, 3'd5, 0, 1, 0, 0, 0, 0);
    add_row(1, 3'd6, 0, 0, 0, 0, 0, 0);
    add_row(1, NT_C, 0, 0, 0, 0, 0, 0);
    add_row(1, NT_A, 1, 0, 1, 5, 0, 0);
    // Setting 2: 5' all code 7 with length 31 (clamped to 16), 3' length 3.
    // Ten 7s: the 5' pattern outruns the read, the 3' one is too short.
    for (int i = 0; i < 9; i++) add_row(2, 3'd7, 0, 0, 0, 0, 0, 0);
    add_row(2, 3'd7, 1, 0, 1, 10, 0, 0);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    cur_setting = 0;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].setting != cur_setting) begin
        cur_setting = dir_rows[r].setting;
        drain_reads();
        case (cur_setting)
          1:       load_config(48'h0_1A21B, 5'd6, 48'h0_12C2, 5'd5);
          default: load_config('1, 5'd31, '0, 5'd3);
        endcase
      end
      offer_base(dir_rows[r].it, dir_rows[r].pinned, dir_rows[r].len,
                 dir_rows[r].five_ov, dir_rows[r].three_ov);
    end

    // Random part: three idling modes, four register settings each.
    // The first setting covers the register extremes once more.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin src_idle_pct = 37; snk_idle_pct = 88; end
        1: begin src_idle_pct = 88; snk_idle_pct = 37; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        drain_reads();
        if (mode == 0 && ph == 0)
          load_config('0, 5'd0, '1, 5'd31);
        else
          load_config(random_pattern(), random_length(), random_pattern(),
                      random_length());
        // long receiver hold-off at full input rate: the result register
        // and the compare stage fill, and the block has to stall its input
        if (mode == 2 && ph == 1) recv_hold = 400;
        phase_bases = 0;
        while (phase_bases < PHASE_BASES) play_read();
      end
    end

    drain_reads();
    $display("Run covered %0d bases and %0d checked reads over %0d register settings,",
             bases_taken, reads_checked, settings_run);
    $display("with idling on either side, none, and a long receiver hold-off.");
    if (errors == 0) begin
      $display("** read_end_overlap_stats_top: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** read_end_overlap_stats_top: FAILED **");
    end
    $finish;
  end

endmodule
